@@ design/rttp_pkg.sv @@
package rttp_pkg;

    // Input and result payloads
    typedef struct packed {
        logic [7:0] pixel_index;
        logic       drain;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       image_done;
        logic [2:0] status;
    } out_t;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_MODE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_BIT_MODE = 2'd3;

    // Tile modes
    localparam logic [1:0] MODE_FB   = 2'd0;
    localparam logic [1:0] MODE_T8   = 2'd1;
    localparam logic [1:0] MODE_T16  = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    // Status codes
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_SIZE    = 3'd1;
    localparam logic [2:0] STATUS_BPP     = 3'd2;
    localparam logic [2:0] STATUS_MODE    = 3'd3;
    localparam logic [2:0] STATUS_OVERRUN = 3'd4;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // Reset values of the configuration registers
    localparam logic [10:0] RESET_WIDTH  = 11'd8;
    localparam logic [12:0] RESET_HEIGHT = 13'd8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result as decided by the front, before the band store data is known
    typedef struct packed {
        logic       from_ram;
        logic       four_bit;
        logic [7:0] direct_byte;
        logic       image_done;
        logic [2:0] status;
    } tok_t;

    // Queue entry: token plus the two store bytes read for it
    typedef struct packed {
        tok_t       tok;
        logic [7:0] ram_hi;
        logic [7:0] ram_lo;
    } entry_t;

endpackage

@@ design/rttp_ram.sv @@
module rttp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/rttp_front.sv @@
module rttp_front
    import rttp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int BAND_LINES = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]                     cfg_index,
    input  logic [CFG_DATA_W-1:0]                      cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  in_t                                        in_data,
    input  logic [QCNT_W-1:0]                          q_level,
    output logic                                       ram_we,
    output logic [$clog2(2*BAND_LINES*MAX_WIDTH)-1:0]  ram_waddr,
    output logic [7:0]                                 ram_wdata,
    output logic [$clog2(2*BAND_LINES*MAX_WIDTH)-1:0]  ram_raddr_a,
    output logic [$clog2(2*BAND_LINES*MAX_WIDTH)-1:0]  ram_raddr_b,
    input  logic [7:0]                                 ram_rdata_a,
    input  logic [7:0]                                 ram_rdata_b,
    output logic                                       push_valid,
    output entry_t                                     push_entry
);

    localparam int AW        = $clog2(2 * BAND_LINES * MAX_WIDTH);
    localparam int BANK_SIZE = BAND_LINES * MAX_WIDTH;
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RPW       = $clog2(MAX_WIDTH * BAND_LINES);
    localparam int PXW       = RPW + 2;
    localparam int CXW       = PXW - 3;
    localparam bit NO_T16    = (BAND_LINES < 16);
    localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);

    // configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  mode_reg;
    logic        four_reg;

    // write side
    logic [CW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic          wbank_reg, wbank_next;
    // read side
    logic [RPW-1:0] rp_reg, rp_next;
    logic           rbank_reg, rbank_next;
    logic [1:0]     pending_reg, pending_next;
    logic [9:0]     emitted_reg, emitted_next;

    // stage aligned with the store read
    logic s1_valid_reg, s1_valid_next;
    tok_t s1_tok_reg, s1_tok_next;

    logic        acc;
    logic        mode16;
    logic [3:0]  row_mask;
    logic [2:0]  cfg_status;
    logic        size_bad;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic [16:0] rp_inc;
    logic [16:0] bb_full;
    logic [16:0] band_bytes;
    logic [10:0] emitted_inc;
    logic [10:0] band_count;
    logic [1:0]  pending_w;
    logic [2:0]  st_w;
    logic [QCNT_W:0] level_sum;

    logic [PXW-1:0] p;
    logic [3:0]     r_rd;
    logic [CXW-1:0] c_rd;

    assign acc      = in_valid && in_ready;
    assign mode16   = (mode_reg == MODE_T16);
    assign row_mask = mode16 ? 4'hF : 4'h7;

    assign level_sum = {1'b0, q_level} + {{QCNT_W{1'b0}}, s1_valid_reg};
    assign in_ready  = (level_sum < (QCNT_W + 1)'(QUEUE_DEPTH));

    // configuration checks: mode, then bits per pixel, then size
    always_comb
    begin
        size_bad = (width_reg == 11'd0) || ({2'b00, width_reg} > MAX_W) ||
                   (height_reg == 13'd0) || (height_reg > MAX_HEIGHT);
        if (mode_reg != MODE_FB)
        begin
            if (mode16)
            begin
                size_bad = size_bad || (width_reg[3:0] != 4'd0) || (height_reg[3:0] != 4'd0);
            end
            else
            begin
                size_bad = size_bad || (width_reg[2:0] != 3'd0) || (height_reg[2:0] != 3'd0);
            end
        end
        if ((mode_reg == MODE_BAD) || (mode16 && NO_T16))
        begin
            cfg_status = STATUS_MODE;
        end
        else if ((mode_reg == MODE_FB) && four_reg)
        begin
            cfg_status = STATUS_BPP;
        end
        else if (size_bad)
        begin
            cfg_status = STATUS_SIZE;
        end
        else
        begin
            cfg_status = STATUS_OK;
        end
    end

    // read address of the next tile-ordered pixel (pair in 4bpp)
    always_comb
    begin
        p = four_reg ? PXW'({rp_reg, 1'b0}) : PXW'(rp_reg);
        if (mode16)
        begin
            r_rd = {p[7], p[5:3]};
            c_rd = CXW'({p[PXW-1:8], p[6], p[2:0]});
        end
        else
        begin
            r_rd = {1'b0, p[5:3]};
            c_rd = {p[PXW-1:6], p[2:0]};
        end
    end

    assign ram_raddr_a = (rbank_reg ? AW'(BANK_SIZE) : AW'(0)) +
                         AW'(r_rd) * AW'(MAX_WIDTH) + AW'(c_rd);
    assign ram_raddr_b = ram_raddr_a + AW'(1);

    assign ram_waddr = (wbank_reg ? AW'(BANK_SIZE) : AW'(0)) +
                       AW'(row_reg[3:0] & row_mask) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign ram_wdata = in_data.pixel_index;

    assign col_inc     = 13'(col_reg) + 13'd1;
    assign row_inc     = {1'b0, row_reg} + 13'd1;
    assign rp_inc      = 17'(rp_reg) + 17'd1;
    assign bb_full     = mode16 ? {2'b00, width_reg, 4'b0000} : {3'b000, width_reg, 3'b000};
    assign band_bytes  = four_reg ? (bb_full >> 1) : bb_full;
    assign emitted_inc = {1'b0, emitted_reg} + 11'd1;
    assign band_count  = mode16 ? 11'(height_reg >> 4) : 11'(height_reg >> 3);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        wbank_next    = wbank_reg;
        rp_next       = rp_reg;
        rbank_next    = rbank_reg;
        pending_next  = pending_reg;
        emitted_next  = emitted_reg;
        s1_valid_next = 1'b0;
        s1_tok_next   = s1_tok_reg;
        ram_we        = 1'b0;
        pending_w     = pending_reg;
        st_w          = STATUS_OK;

        if (cfg_we)
        begin
            // any register write restarts the image
            col_next     = '0;
            row_next     = '0;
            wbank_next   = 1'b0;
            rp_next      = '0;
            rbank_next   = 1'b0;
            pending_next = '0;
            emitted_next = '0;
        end
        else if (acc)
        begin
            s1_tok_next.from_ram    = 1'b0;
            s1_tok_next.four_bit    = four_reg;
            s1_tok_next.direct_byte = 8'd0;
            s1_tok_next.image_done  = 1'b0;
            s1_tok_next.status      = STATUS_OK;
            if (cfg_status != STATUS_OK)
            begin
                s1_valid_next      = !in_data.drain;
                s1_tok_next.status = cfg_status;
            end
            else if (mode_reg == MODE_FB)
            begin
                if (!in_data.drain)
                begin
                    s1_valid_next           = 1'b1;
                    s1_tok_next.direct_byte = in_data.pixel_index;
                    if (col_inc >= {2'b00, width_reg})
                    begin
                        col_next = '0;
                        if (row_inc >= height_reg)
                        begin
                            row_next               = '0;
                            s1_tok_next.image_done = 1'b1;
                        end
                        else
                        begin
                            row_next = row_inc[11:0];
                        end
                    end
                    else
                    begin
                        col_next = CW'(col_inc);
                    end
                end
            end
            else
            begin
                if (!in_data.drain)
                begin
                    if (pending_reg >= 2'd2)
                    begin
                        st_w = STATUS_OVERRUN;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (col_inc >= {2'b00, width_reg})
                        begin
                            col_next = '0;
                            if ((row_inc[3:0] & row_mask) == 4'd0)
                            begin
                                pending_w  = pending_reg + 2'd1;
                                wbank_next = !wbank_reg;
                            end
                            row_next = (row_inc >= height_reg) ? 12'd0 : row_inc[11:0];
                        end
                        else
                        begin
                            col_next = CW'(col_inc);
                        end
                    end
                end
                if (pending_w != 2'd0)
                begin
                    s1_valid_next        = 1'b1;
                    s1_tok_next.from_ram = 1'b1;
                    s1_tok_next.status   = st_w;
                    if (rp_inc >= band_bytes)
                    begin
                        rp_next    = '0;
                        rbank_next = !rbank_reg;
                        pending_w  = pending_w - 2'd1;
                        if (emitted_inc >= band_count)
                        begin
                            emitted_next           = '0;
                            s1_tok_next.image_done = 1'b1;
                        end
                        else
                        begin
                            emitted_next = emitted_inc[9:0];
                        end
                    end
                    else
                    begin
                        rp_next = RPW'(rp_inc);
                    end
                end
                pending_next = pending_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RESET_WIDTH;
            height_reg   <= RESET_HEIGHT;
            mode_reg     <= MODE_T8;
            four_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            wbank_reg    <= 1'b0;
            rp_reg       <= '0;
            rbank_reg    <= 1'b0;
            pending_reg  <= '0;
            emitted_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data[10:0];
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data[12:0];
                    REG_TILE_MODE:     mode_reg   <= cfg_data[1:0];
                    REG_FOUR_BIT_MODE: four_reg   <= cfg_data[0];
                    default:           four_reg   <= four_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            wbank_reg    <= wbank_next;
            rp_reg       <= rp_next;
            rbank_reg    <= rbank_next;
            pending_reg  <= pending_next;
            emitted_reg  <= emitted_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tok_reg <= s1_tok_next;
    end

    // store data lands together with the token
    assign push_valid        = s1_valid_reg;
    assign push_entry.tok    = s1_tok_reg;
    assign push_entry.ram_hi = ram_rdata_a;
    assign push_entry.ram_lo = ram_rdata_b;

endmodule

@@ design/rttp_queue.sv @@
module rttp_queue
    import rttp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  entry_t            push_entry,
    input  logic              pop,
    output logic [QCNT_W-1:0] level,
    output logic              head_valid,
    output entry_t            head_entry
);

    entry_t             slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // front never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_valid) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot[wr_ptr_reg] <= push_entry;
        end
    end

    assign level      = count_reg;
    assign head_valid = (count_reg != '0);
    assign head_entry = slot[rd_ptr_reg];

endmodule

@@ design/rttp_back.sv @@
module rttp_back
    import rttp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   head_valid,
    input  entry_t head_entry,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output out_t   out_data
);

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    // byte assembly: store byte, packed nibble pair, or direct byte
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (!head_entry.tok.from_ram)
            begin
                out_data_next.out_byte = head_entry.tok.direct_byte;
            end
            else if (head_entry.tok.four_bit)
            begin
                out_data_next.out_byte = {head_entry.ram_hi[3:0], head_entry.ram_lo[3:0]};
            end
            else
            begin
                out_data_next.out_byte = head_entry.ram_hi;
            end
            out_data_next.image_done = head_entry.tok.image_done;
            out_data_next.status     = head_entry.tok.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/raster_to_tile_reorder_packer.sv @@
// Throughput: one input transfer per cycle while in_ready is high, one result
// per cycle while out_ready is high; the single band store write port and its
// two registered read ports each serve one item a cycle.
// Reset: asynchronous, active low; registers return to 8x8 pixels, 8x8 tiles, 8bpp,
// all counters and pending bands cleared. The band store needs no clearing pass.
module raster_to_tile_reorder_packer
    import rttp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int BAND_LINES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data
);

    // Two bands of BAND_LINES rows, ping-pong
    localparam int STORE_DEPTH = 2 * BAND_LINES * MAX_WIDTH;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr_a;
    logic [AW-1:0]     ram_raddr_b;
    logic [7:0]        ram_rdata_a;
    logic [7:0]        ram_rdata_b;

    logic              push_valid;
    entry_t            push_entry;
    logic [QCNT_W-1:0] q_level;
    logic              pop;
    logic              head_valid;
    entry_t            head_entry;

    // Front: holds the registers, checks the configuration, writes pixels into
    // the filling band and works out which byte of the oldest finished band goes
    // out next. Its read is issued in the transfer cycle; the token waits one
    // stage for the store data and then enters the queue. The front takes a
    // transfer only while the queue, counting that stage, has a free slot.
    rttp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .BAND_LINES (BAND_LINES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .q_level     (q_level),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    // Band store. Port a reads the byte (or the high nibble's pixel), port b the
    // neighbouring column for the low nibble in 4bpp. Writes always go to the
    // bank being filled, reads to a finished bank, so they never collide.
    rttp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Short queue so a stalled output side does not hold up the front at once
    rttp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .level      (q_level),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back: packs the byte and holds it in the output register until transfer
    rttp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
